FILE: rtl/kcld_pkg.sv
// Shared types and codes for the key click / long-press detector.
`timescale 1ns / 1ps

package kcld_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int FILT_W      = 10;   // holds 2*255 + 255

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODE_MASK     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_PERIOD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_TIME     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_TIME   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MULTI_WINDOW  = 3'd4;

    // Mode mask bits
    localparam int MB_CLICK_BIT  = 0;
    localparam int MB_DOUBLE_BIT = 1;
    localparam int MB_LONG_BIT   = 2;
    localparam int MB_REPEAT_BIT = 3;

    localparam logic [7:0] FILTER_TIME_RST  = 8'd30;
    localparam logic [15:0] MULTI_WINDOW_RST = 16'd250;
    localparam logic [7:0] CLICK_MAX        = 8'd255;

    typedef enum logic [2:0] {
        EV_CLICK   = 3'd0,
        EV_MULTI   = 3'd1,
        EV_LONG    = 3'd2,
        EV_REPEAT  = 3'd3,
        EV_RELEASE = 3'd4
    } event_t;

    typedef enum logic [6:0] {
        PM_RELEASED = 7'b0000001,
        PM_SD       = 7'b0000010,
        PM_D        = 7'b0000100,
        PM_S        = 7'b0001000,
        PM_LR       = 7'b0010000,
        PM_L        = 7'b0100000,
        PM_R        = 7'b1000000
    } press_mode_t;

    typedef struct packed {
        logic [3:0]  mode_mask;
        logic [15:0] repeat_period;
        logic [15:0] long_press_time;
        logic [7:0]  filter_time;
        logic [15:0] multi_click_window;
    } cfg_t;

    typedef struct packed {
        logic pressed;
        logic released;
    } act_t;

endpackage

FILE: rtl/key_click_longpress_detector.sv
// Top level of the single-key click / multi-click / long-press detector.
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  in       | in_valid, in_stall, key_down,    | beat in
//           | tick_ms                          |
//  out      | out_valid, out_stall, event_code,| beat out
//           | click_total                      |
//  cfg      | cfg_we, cfg_index, cfg_data      | write only
//
// One scan tick per cycle while in_stall is low; a tick's event passes through
// the input register, then the result register.
// The debounce filter and press-mode state update in the cycle a tick moves
// from the input register into the result stage.
// in_stall rises only while the result register is full and stalled.
// Reset clears the valid flags, filter and press-mode state and loads the register defaults.
`timescale 1ns / 1ps

module key_click_longpress_detector
    import kcld_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   key_down,
    input  logic [7:0]             tick_ms,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             event_code,
    output logic [7:0]             click_total,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t       cfg_reg;
    logic       s1_valid_reg;
    logic       s1_down_reg;
    logic [7:0] s1_tick_reg;
    logic       out_valid_reg;
    event_t     event_reg;
    logic [7:0] total_reg;

    logic       advance;
    logic       fire;
    logic       in_take;
    act_t       act;
    logic       ev_valid;
    event_t     ev_code;
    logic [7:0] ev_count;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_mask          <= '0;
            cfg_reg.repeat_period      <= '0;
            cfg_reg.long_press_time    <= '0;
            cfg_reg.filter_time        <= FILTER_TIME_RST;
            cfg_reg.multi_click_window <= MULTI_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE_MASK:     cfg_reg.mode_mask          <= cfg_data[3:0];
                REG_REPEAT_PERIOD: cfg_reg.repeat_period      <= cfg_data;
                REG_LONG_TIME:     cfg_reg.long_press_time    <= cfg_data;
                REG_FILTER_TIME:   cfg_reg.filter_time        <= cfg_data[7:0];
                REG_MULTI_WINDOW:  cfg_reg.multi_click_window <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: load whenever the slot is free or being drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_down_reg <= key_down;
            s1_tick_reg <= tick_ms;
        end
    end

    kcld_filter u_filter (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .key_down    (s1_down_reg),
        .tick_ms     (s1_tick_reg),
        .filter_time (cfg_reg.filter_time),
        .act         (act)
    );

    kcld_press #(
        .TIME_BITS (TIME_BITS)
    ) u_press (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .act      (act),
        .tick_ms  (s1_tick_reg),
        .cfg      (cfg_reg),
        .ev_valid (ev_valid),
        .ev_code  (ev_code),
        .ev_count (ev_count)
    );

    // Result register: load whenever the slot is free or being drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg && ev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (fire && ev_valid)
        begin
            event_reg <= ev_code;
            total_reg <= ev_count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_code  = event_reg;
    assign click_total = total_reg;

endmodule

FILE: rtl/kcld_filter.sv
// Time-based debounce filter: decides which level action a scan tick runs.
`timescale 1ns / 1ps

module kcld_filter
    import kcld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic       key_down,
    input  logic [7:0] tick_ms,
    input  logic [7:0] filter_time,
    output act_t       act
);

    logic [FILT_W-1:0] filt_reg;
    logic [FILT_W-1:0] filt_next;
    logic [FILT_W-1:0] f_one;
    logic [FILT_W-1:0] f_two;
    logic [FILT_W-1:0] t_ext;

    assign f_one = FILT_W'(filter_time);
    assign f_two = FILT_W'({filter_time, 1'b0});
    assign t_ext = FILT_W'(tick_ms);

    always_comb
    begin
        filt_next    = filt_reg;
        act.pressed  = 1'b0;
        act.released = 1'b0;
        if (key_down)
        begin
            priority if (filt_reg < f_one)
                filt_next = f_one;
            else if (filt_reg < f_two)
                filt_next = filt_reg + t_ext;
            else
                act.pressed = 1'b1;
        end
        else
        begin
            priority if (filt_reg > f_one)
                filt_next = f_one;
            else if (filt_reg != '0)
                filt_next = (filt_reg >= t_ext) ? filt_reg - t_ext : '0;
            else
                act.released = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            filt_reg <= '0;
        else if (fire)
            filt_reg <= filt_next;
    end

endmodule

FILE: rtl/kcld_press.sv
// Press-mode state machine with hold, repeat and gap timers.
`timescale 1ns / 1ps

module kcld_press
    import kcld_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  act_t       act,
    input  logic [7:0] tick_ms,
    input  cfg_t       cfg,
    output logic       ev_valid,
    output event_t     ev_code,
    output logic [7:0] ev_count
);

    localparam int TW = TIME_BITS + 1;
    localparam int CW = (TW > 16) ? TW : 16;

    press_mode_t   mode_reg,   mode_next;
    logic          level_reg,  level_next;
    logic [TW-1:0] hold_reg,   hold_next;
    logic [TW-1:0] rep_reg,    rep_next;
    logic [TW-1:0] gap_reg,    gap_next;
    logic [7:0]    clicks_reg, clicks_next;

    logic [TW:0]   hold_sum, rep_sum, gap_sum;
    logic [TW-1:0] hold_add, rep_add, gap_add;
    logic [7:0]    clicks_inc;
    logic          lp, rp, ck, dc;
    logic          hold_short, hold_reached, rep_reached, gap_reached;

    assign ck = cfg.mode_mask[MB_CLICK_BIT];
    assign dc = cfg.mode_mask[MB_DOUBLE_BIT];
    assign lp = cfg.mode_mask[MB_LONG_BIT];
    assign rp = cfg.mode_mask[MB_REPEAT_BIT];

    // Saturating timer adds
    assign hold_sum = {1'b0, hold_reg} + (TW + 1)'(tick_ms);
    assign rep_sum  = {1'b0, rep_reg}  + (TW + 1)'(tick_ms);
    assign gap_sum  = {1'b0, gap_reg}  + (TW + 1)'(tick_ms);
    assign hold_add = hold_sum[TW] ? '1 : hold_sum[TW-1:0];
    assign rep_add  = rep_sum[TW]  ? '1 : rep_sum[TW-1:0];
    assign gap_add  = gap_sum[TW]  ? '1 : gap_sum[TW-1:0];

    assign hold_short   = CW'(hold_reg) < CW'(cfg.long_press_time);
    assign hold_reached = CW'(hold_add) >= CW'(cfg.long_press_time);
    assign rep_reached  = CW'(rep_add)  >= CW'(cfg.repeat_period);
    assign gap_reached  = CW'(gap_add)  >= CW'(cfg.multi_click_window);

    assign clicks_inc = (clicks_reg == CLICK_MAX) ? clicks_reg : clicks_reg + 8'd1;

    always_comb
    begin
        mode_next   = mode_reg;
        level_next  = level_reg;
        hold_next   = hold_reg;
        rep_next    = rep_reg;
        gap_next    = gap_reg;
        clicks_next = clicks_reg;
        ev_valid    = 1'b0;
        ev_code     = EV_CLICK;
        ev_count    = clicks_reg;

        if (act.pressed)
        begin
            if (!level_reg)
            begin
                // debounced press edge
                level_next = 1'b1;
                if (mode_reg == PM_RELEASED)
                begin
                    clicks_next = 8'd1;
                    gap_next    = '0;
                    hold_next   = '0;
                    rep_next    = '0;
                    priority if (ck && dc)
                        mode_next = PM_SD;
                    else if (ck)
                    begin
                        mode_next = PM_S;
                        if (!lp && !rp)
                        begin
                            ev_valid = 1'b1;
                            ev_code  = EV_CLICK;
                            ev_count = 8'd1;
                        end
                    end
                    else if (dc)
                        mode_next = PM_D;
                    else
                        mode_next = PM_RELEASED;
                end
                else if (mode_reg == PM_SD || mode_reg == PM_D)
                begin
                    gap_next    = '0;
                    clicks_next = clicks_inc;
                end
            end
            else
            begin
                // key held
                priority if (lp && rp)
                begin
                    if (hold_short)
                    begin
                        hold_next = hold_add;
                        if (hold_reached)
                        begin
                            rep_next  = '0;
                            mode_next = PM_LR;
                        end
                    end
                    else if (rep_reached)
                    begin
                        rep_next    = '0;
                        mode_next   = PM_LR;
                        clicks_next = clicks_inc;
                        ev_valid    = 1'b1;
                        ev_code     = EV_REPEAT;
                    end
                    else
                        rep_next = rep_add;
                end
                else if (lp)
                begin
                    if (hold_short)
                    begin
                        hold_next = hold_add;
                        if (hold_reached)
                        begin
                            mode_next = PM_L;
                            ev_valid  = 1'b1;
                            ev_code   = EV_LONG;
                        end
                    end
                end
                else if (rp)
                begin
                    if (rep_reached)
                    begin
                        rep_next    = '0;
                        mode_next   = PM_R;
                        clicks_next = clicks_inc;
                        ev_valid    = 1'b1;
                        ev_code     = EV_REPEAT;
                    end
                    else
                        rep_next = rep_add;
                end
                else
                    // no timed action without long press or repeat
                    hold_next = hold_reg;
            end
        end
        else if (act.released)
        begin
            level_next = 1'b0;
            unique case (mode_reg)
                PM_SD, PM_D:
                begin
                    if (gap_reached)
                    begin
                        mode_next   = PM_RELEASED;
                        gap_next    = '0;
                        clicks_next = 8'd0;
                        ev_valid    = 1'b1;
                        ev_code     = (mode_reg == PM_SD && clicks_reg <= 8'd1)
                                      ? EV_CLICK : EV_MULTI;
                    end
                    else
                        gap_next = gap_add;
                end
                PM_S:
                begin
                    mode_next = PM_RELEASED;
                    ev_valid  = 1'b1;
                    ev_code   = (!lp && !rp) ? EV_RELEASE : EV_CLICK;
                end
                PM_LR, PM_L, PM_R:
                begin
                    mode_next = PM_RELEASED;
                    ev_valid  = 1'b1;
                    ev_code   = EV_RELEASE;
                end
                default:
                    mode_next = PM_RELEASED;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= PM_RELEASED;
            level_reg  <= 1'b0;
            hold_reg   <= '0;
            rep_reg    <= '0;
            gap_reg    <= '0;
            clicks_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            level_reg  <= level_next;
            hold_reg   <= hold_next;
            rep_reg    <= rep_next;
            gap_reg    <= gap_next;
            clicks_reg <= clicks_next;
        end
    end

endmodule

FILE: rtl/kcld_checker.sv
// Port-level checks for the key detector, bound to the top level.
`timescale 1ns / 1ps

module kcld_checker
    import kcld_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [2:0]             event_code,
    input logic [7:0]             click_total
);

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_code)
                                   && $stable(click_total))
        else $error("stalled result beat changed");

    // Input backpressure comes only from a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_stall)
        else $error("input stalled without output stall");

    // A new result needs a matching input beat taken into the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without matching input beat");

    // Every event carries at least one click
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> click_total != 8'd0)
        else $error("event with zero click count");

endmodule

bind key_click_longpress_detector kcld_checker u_kcld_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_code  (event_code),
    .click_total (click_total)
);
